// File: rtl/jlvr_pkg.sv
package jlvr_pkg;

  localparam int unsigned DATA_WIDTH = 32;

  localparam int unsigned IW     = 64;
  localparam int unsigned IO_W   = 32;
  localparam int unsigned MA_W   = 31;
  localparam int unsigned MJ_W   = 31;
  localparam int unsigned CT_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW = 31;

  localparam int unsigned MUL_AW = 64;
  localparam int unsigned MUL_BW = 32;
  localparam int unsigned PROD_W = MUL_AW + MUL_BW;

  localparam int unsigned SQ_W   = 64;
  localparam int unsigned ROOT_W = 32;

  localparam int unsigned DVSR_W = 24;

  localparam int unsigned TS_SHIFT = 24;
  localparam int unsigned DV_SHIFT = 25;

  localparam logic [MA_W-1:0] MAX_ACCEL_RST  = 31'd65536;
  localparam logic [MJ_W-1:0] MAX_JERK_RST   = 31'd655360;
  localparam logic [CT_W-1:0] CYCLE_TIME_RST = 24'd16777;

  // floor(x / 1000) = (x * DEADBAND_RECIP) >> DEADBAND_SHIFT for any 32-bit x
  localparam logic [MUL_BW-1:0] DEADBAND_RECIP = 32'h1062_4DD3;
  localparam int unsigned       DEADBAND_SHIFT = 38;

  localparam logic REQ_STEP   = 1'b0;
  localparam logic REQ_PRESET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ACCEL  = 2'd0,
    CFG_MAX_JERK   = 2'd1,
    CFG_CYCLE_TIME = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DMAX,
    S_TINY_M,
    S_TINY_D,
    S_SQ,
    S_ERRM,
    S_SQRT,
    S_LIM,
    S_DV,
    S_OVDIV,
    S_OVMUL,
    S_JDIV,
    S_DONE
  } state_e;

endpackage

// File: rtl/jerk_limited_velocity_ramp_top.sv
// A preset goes straight from idle to the done state; a step runs the multiply
// steps, the braking root only outside the deadband, the overshoot path only on
// overshoot, and then the jerk divide (divider width max(DATA_WIDTH+26,63)).
// One request at a time: a single serial multiplier, divider and square-root
// unit run in turn under the sequencer; in_stall_o is high until it is idle again.
// Reset: velocity and acceleration clear to zero, limits load their defaults.
module jerk_limited_velocity_ramp_top #(
  parameter int unsigned DATA_WIDTH = jlvr_pkg::DATA_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [jlvr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [jlvr_pkg::CFG_DW-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic signed [jlvr_pkg::IO_W-1:0]    target_velocity_i,
  input  logic signed [jlvr_pkg::IO_W-1:0]    preset_velocity_i,
  input  logic signed [jlvr_pkg::IO_W-1:0]    preset_accel_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [jlvr_pkg::IO_W-1:0]    new_velocity_o,
  output logic signed [jlvr_pkg::IO_W-1:0]    new_accel_o,
  output logic signed [jlvr_pkg::IO_W-1:0]    jerk_out_o
);

  localparam int unsigned DW     = DATA_WIDTH;
  localparam int unsigned IW     = jlvr_pkg::IW;
  localparam int unsigned IO_W   = jlvr_pkg::IO_W;
  localparam int unsigned DIV_W  = (DW + 26 > 63) ? DW + 26 : 63;
  localparam int unsigned RSUM_W = jlvr_pkg::PROD_W + 2;
  localparam logic signed [IW-1:0] DA_LIM = 64'sh0000_0040_0000_0000;
  localparam logic signed [IW-1:0] Q_SAT  = 64'sh4000_0000_0000_0000;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [IW-1:0] x);
    logic signed [IW-1:0] hi;
    logic signed [IW-1:0] lo;
    hi = {{(IW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    lo = ~hi;
    if (x > hi) return hi[DW-1:0];
    if (x < lo) return lo[DW-1:0];
    return x[DW-1:0];
  endfunction

  jlvr_pkg::state_e state_q, state_d;
  logic go_q, go_d;

  logic [jlvr_pkg::MA_W-1:0] ma_q;
  logic [jlvr_pkg::MJ_W-1:0] mj_q;
  logic [jlvr_pkg::CT_W-1:0] ct_q;

  logic signed [DW-1:0]   v_q, a_q;
  logic signed [IO_W-1:0] tv_q;
  logic [jlvr_pkg::MJ_W-1:0] dmax_q, tinyp_q;
  logic [IW-1:0]          sq_q, rad_q;
  logic signed [IW-1:0]   acc_q, na_q, vn_q, jerk_q;

  logic                   out_valid_q;
  logic signed [IO_W-1:0] out_vel_q, out_acc_q, out_jerk_q;

  logic in_acc, done_fire;
  logic [jlvr_pkg::CT_W-1:0] t_eff;
  logic signed [IW-1:0] v64, a64, tv64, err64, errm, tiny64;
  logic signed [IW-1:0] ma64, mj64, dmax64;
  logic signed [IW-1:0] sum_an, sum_an_m, dvm, dv64, vdv;
  logic signed [IW-1:0] accl, lim_hi, lim_lo, na_lim, acc_root;
  logic signed [IW-1:0] da, da_c, dam, ovq, ov_na, jq, jerk_c;
  logic [jlvr_pkg::ROOT_W-1:0] root_diff;
  logic [RSUM_W-1:0] rsum;
  logic [IW-1:0]     rad;
  logic out_band, overshoot;
  logic signed [DW-1:0] v_sat, na_sat;
  logic signed [IW-1:0] vs64, ns64;

  logic                           mul_start, mul_done;
  logic [jlvr_pkg::MUL_AW-1:0]    mul_a;
  logic [jlvr_pkg::MUL_BW-1:0]    mul_b;
  logic [jlvr_pkg::PROD_W-1:0]    mul_prod;
  logic                           div_start, div_done;
  logic [DIV_W-1:0]               div_dividend, div_quot;
  logic [jlvr_pkg::DVSR_W-1:0]    div_divisor;
  logic                           sqrt_start, sqrt_done;
  logic [jlvr_pkg::ROOT_W-1:0]    sqrt_root;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != jlvr_pkg::S_IDLE);
  assign done_fire  = (state_q == jlvr_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  assign t_eff  = (ct_q == '0) ? jlvr_pkg::CT_W'(1) : ct_q;
  assign v64    = IW'(v_q);
  assign a64    = IW'(a_q);
  assign tv64   = IW'(tv_q);
  assign err64  = tv64 - v64;
  assign errm   = err64[IW-1] ? -err64 : err64;
  assign ma64   = IW'(ma_q);
  assign mj64   = IW'(mj_q);
  assign dmax64 = IW'(dmax_q);
  assign tiny64 = IW'(mul_prod[jlvr_pkg::DEADBAND_SHIFT +: jlvr_pkg::MJ_W]);
  assign out_band = (err64 > tiny64) || (err64 < -tiny64);

  assign rsum = {1'b0, mul_prod, 1'b0} + RSUM_W'(sq_q);
  assign rad  = (|rsum[RSUM_W-1:IW]) ? '1 : rsum[IW-1:0];

  assign root_diff = sqrt_root - jlvr_pkg::ROOT_W'(dmax_q);
  assign acc_root  = (err64 > 0) ? IW'(root_diff) : -IW'(root_diff);

  assign accl   = (acc_q > ma64) ? ma64 : ((acc_q < -ma64) ? -ma64 : acc_q);
  assign lim_hi = a64 + dmax64;
  assign lim_lo = a64 - dmax64;
  assign na_lim = (accl > lim_hi) ? lim_hi : ((accl < lim_lo) ? lim_lo : accl);

  assign sum_an   = a64 + na_q;
  assign sum_an_m = sum_an[IW-1] ? -sum_an : sum_an;
  assign dvm      = mul_prod[jlvr_pkg::DV_SHIFT +: IW];
  assign dv64     = sum_an[IW-1] ? -dvm : dvm;
  assign vdv      = v64 + dv64;
  assign overshoot = (dv64 < 0 && tv64 < v64 && vdv < tv64) ||
                     (dv64 > 0 && v64 < tv64 && tv64 < vdv);

  assign ovq   = (|div_quot[DIV_W-1:62]) ? Q_SAT : IW'(div_quot[61:0]);
  assign ov_na = (err64[IW-1] ? -ovq : ovq) - a64;

  assign da     = na_q - a64;
  assign da_c   = (da > DA_LIM) ? DA_LIM : ((da < -DA_LIM) ? -DA_LIM : da);
  assign dam    = da_c[IW-1] ? -da_c : da_c;
  assign jq     = IW'(div_quot[62:0]);
  assign jerk_c = da_c[IW-1] ? -jq : jq;

  assign v_sat  = sat_dw(vn_q);
  assign na_sat = sat_dw(na_q);
  assign vs64   = IW'(v_sat);
  assign ns64   = IW'(na_sat);

  always_comb begin
    mul_a = sum_an_m;
    mul_b = jlvr_pkg::MUL_BW'(t_eff);
    case (state_q)
      jlvr_pkg::S_DMAX: begin
        mul_a = IW'(mj_q);
      end
      jlvr_pkg::S_TINY_M: begin
        mul_a = IW'(dmax_q);
      end
      jlvr_pkg::S_TINY_D: begin
        mul_a = IW'(tinyp_q);
        mul_b = jlvr_pkg::DEADBAND_RECIP;
      end
      jlvr_pkg::S_SQ: begin
        mul_a = IW'(dmax_q);
        mul_b = jlvr_pkg::MUL_BW'(dmax_q);
      end
      jlvr_pkg::S_ERRM: begin
        mul_a = errm;
        mul_b = jlvr_pkg::MUL_BW'(mj_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_dividend = DIV_W'(dam) << jlvr_pkg::TS_SHIFT;
    div_divisor  = t_eff;
    case (state_q)
      jlvr_pkg::S_OVDIV: begin
        div_dividend = DIV_W'(errm) << jlvr_pkg::DV_SHIFT;
      end
      default: ;
    endcase
  end

  assign mul_start = go_q && (state_q == jlvr_pkg::S_DMAX || state_q == jlvr_pkg::S_TINY_M ||
                              state_q == jlvr_pkg::S_TINY_D ||
                              state_q == jlvr_pkg::S_SQ || state_q == jlvr_pkg::S_ERRM ||
                              state_q == jlvr_pkg::S_DV || state_q == jlvr_pkg::S_OVMUL);
  assign div_start = go_q && (state_q == jlvr_pkg::S_OVDIV || state_q == jlvr_pkg::S_JDIV);
  assign sqrt_start = go_q && (state_q == jlvr_pkg::S_SQRT);

  jlvr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  jlvr_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  jlvr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      jlvr_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (req_type_i == jlvr_pkg::REQ_PRESET) ? jlvr_pkg::S_DONE : jlvr_pkg::S_DMAX;
        end
      end
      jlvr_pkg::S_DMAX: begin
        if (mul_done) state_d = jlvr_pkg::S_TINY_M;
      end
      jlvr_pkg::S_TINY_M: begin
        if (mul_done) state_d = jlvr_pkg::S_TINY_D;
      end
      jlvr_pkg::S_TINY_D: begin
        if (mul_done) state_d = out_band ? jlvr_pkg::S_SQ : jlvr_pkg::S_LIM;
      end
      jlvr_pkg::S_SQ: begin
        if (mul_done) state_d = jlvr_pkg::S_ERRM;
      end
      jlvr_pkg::S_ERRM: begin
        if (mul_done) state_d = jlvr_pkg::S_SQRT;
      end
      jlvr_pkg::S_SQRT: begin
        if (sqrt_done) state_d = jlvr_pkg::S_LIM;
      end
      jlvr_pkg::S_LIM: begin
        state_d = jlvr_pkg::S_DV;
      end
      jlvr_pkg::S_DV: begin
        if (mul_done) state_d = overshoot ? jlvr_pkg::S_OVDIV : jlvr_pkg::S_JDIV;
      end
      jlvr_pkg::S_OVDIV: begin
        if (div_done) state_d = (ov_na >= ma64) ? jlvr_pkg::S_OVMUL : jlvr_pkg::S_JDIV;
      end
      jlvr_pkg::S_OVMUL: begin
        if (mul_done) state_d = jlvr_pkg::S_JDIV;
      end
      jlvr_pkg::S_JDIV: begin
        if (div_done) state_d = jlvr_pkg::S_DONE;
      end
      jlvr_pkg::S_DONE: begin
        if (done_fire) state_d = jlvr_pkg::S_IDLE;
      end
      default: begin
        state_d = jlvr_pkg::S_IDLE;
      end
    endcase
    go_d = (state_d != state_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jlvr_pkg::S_IDLE;
      go_q        <= 1'b0;
      v_q         <= '0;
      a_q         <= '0;
      out_valid_q <= 1'b0;
      ma_q        <= jlvr_pkg::MAX_ACCEL_RST;
      mj_q        <= jlvr_pkg::MAX_JERK_RST;
      ct_q        <= jlvr_pkg::CYCLE_TIME_RST;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      if (done_fire) begin
        v_q         <= v_sat;
        a_q         <= na_sat;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          jlvr_pkg::CFG_MAX_ACCEL:  ma_q <= cfg_wdata_i;
          jlvr_pkg::CFG_MAX_JERK:   mj_q <= cfg_wdata_i;
          jlvr_pkg::CFG_CYCLE_TIME: ct_q <= cfg_wdata_i[jlvr_pkg::CT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      jlvr_pkg::S_IDLE: begin
        if (in_acc) begin
          tv_q   <= target_velocity_i;
          vn_q   <= IW'(preset_velocity_i);
          na_q   <= IW'(preset_accel_i);
          jerk_q <= '0;
        end
      end
      jlvr_pkg::S_DMAX: begin
        if (mul_done) dmax_q <= mul_prod[jlvr_pkg::TS_SHIFT +: jlvr_pkg::MJ_W];
      end
      jlvr_pkg::S_TINY_M: begin
        if (mul_done) tinyp_q <= mul_prod[jlvr_pkg::TS_SHIFT +: jlvr_pkg::MJ_W];
      end
      jlvr_pkg::S_TINY_D: begin
        if (mul_done && !out_band) acc_q <= '0;
      end
      jlvr_pkg::S_SQ: begin
        if (mul_done) sq_q <= mul_prod[IW-1:0];
      end
      jlvr_pkg::S_ERRM: begin
        if (mul_done) rad_q <= rad;
      end
      jlvr_pkg::S_SQRT: begin
        if (sqrt_done) acc_q <= acc_root;
      end
      jlvr_pkg::S_LIM: begin
        na_q <= na_lim;
      end
      jlvr_pkg::S_DV: begin
        if (mul_done && !overshoot) vn_q <= vdv;
      end
      jlvr_pkg::S_OVDIV: begin
        if (div_done) begin
          if (ov_na >= ma64) begin
            na_q <= ma64;
          end else begin
            vn_q <= tv64;
            na_q <= ov_na;
          end
        end
      end
      jlvr_pkg::S_OVMUL: begin
        if (mul_done) vn_q <= vdv;
      end
      jlvr_pkg::S_JDIV: begin
        if (div_done) begin
          if (jerk_c > mj64) begin
            jerk_q <= mj64;
            na_q   <= lim_hi;
          end else if (jerk_c < -mj64) begin
            jerk_q <= -mj64;
            na_q   <= lim_lo;
          end else begin
            jerk_q <= jerk_c;
          end
        end
      end
      jlvr_pkg::S_DONE: begin
        if (done_fire) begin
          out_vel_q  <= vs64[IO_W-1:0];
          out_acc_q  <= ns64[IO_W-1:0];
          out_jerk_q <= jerk_q[IO_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign new_velocity_o = out_vel_q;
  assign new_accel_o    = out_acc_q;
  assign jerk_out_o     = out_jerk_q;

`ifndef SYNTH
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == jlvr_pkg::S_DMAX || state_q == jlvr_pkg::S_TINY_M ||
                  state_q == jlvr_pkg::S_TINY_D ||
                  state_q == jlvr_pkg::S_SQ || state_q == jlvr_pkg::S_ERRM ||
                  state_q == jlvr_pkg::S_DV || state_q == jlvr_pkg::S_OVMUL))
    else $error("multiplier finished outside a multiply step");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == jlvr_pkg::S_OVDIV || state_q == jlvr_pkg::S_JDIV))
    else $error("divider finished outside a divide step");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != jlvr_pkg::S_IDLE))
    else $error("accepted transfer did not start the sequencer");

  a_jerk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire |-> (jerk_q <= mj64 && jerk_q >= -mj64))
    else $error("jerk result exceeds the jerk limit");
`endif

endmodule

// File: rtl/jlvr_mul.sv
module jlvr_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [jlvr_pkg::MUL_AW-1:0]       a_i,
  input  logic [jlvr_pkg::MUL_BW-1:0]       b_i,
  output logic                              done_o,
  output logic [jlvr_pkg::PROD_W-1:0]       prod_o
);

  localparam int unsigned AW    = jlvr_pkg::MUL_AW;
  localparam int unsigned BW    = jlvr_pkg::MUL_BW;
  localparam int unsigned CNT_W = $clog2(BW);

  logic [AW-1:0]    a_q;
  logic [AW-1:0]    hi_q, hi_d;
  logic [BW-1:0]    lo_q, lo_d;
  logic [AW:0]      sum;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
  assign hi_d = sum[AW:1];
  assign lo_d = {sum[0], lo_q[BW-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// File: rtl/jlvr_div.sv
module jlvr_div #(
  parameter int unsigned DIV_W = 63
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [DIV_W-1:0]                  dividend_i,
  input  logic [jlvr_pkg::DVSR_W-1:0]       divisor_i,
  output logic                              done_o,
  output logic [DIV_W-1:0]                  quot_o
);

  localparam int unsigned DW_S  = jlvr_pkg::DVSR_W;
  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DW_S-1:0]  dvs_q;
  logic [DW_S-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DW_S:0]    shifted, trial;
  logic             fits;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign trial   = shifted - {1'b0, dvs_q};
  assign rem_d   = fits ? trial[DW_S-1:0] : shifted[DW_S-1:0];
  assign quo_d   = {quo_q[DIV_W-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: rtl/jlvr_sqrt.sv
module jlvr_sqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [jlvr_pkg::SQ_W-1:0]         rad_i,
  output logic                              done_o,
  output logic [jlvr_pkg::ROOT_W-1:0]       root_o
);

  localparam int unsigned XW    = jlvr_pkg::SQ_W;
  localparam int unsigned RW    = jlvr_pkg::ROOT_W;
  localparam int unsigned REM_W = RW + 3;
  localparam int unsigned CNT_W = $clog2(RW);

  logic [XW-1:0]      x_q;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [RW-1:0]      root_q, root_d;
  logic [REM_W+1:0]   shifted, trial, diff;
  logic               ge;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;

  assign shifted = {rem_q, x_q[XW-1 -: 2]};
  assign trial   = (REM_W + 2)'({root_q, 2'b01});
  assign ge      = shifted >= trial;
  assign diff    = shifted - trial;
  assign rem_d   = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
  assign root_d  = {root_q[RW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(RW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= x_q << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: dv/jerk_limited_velocity_ramp_top_tb.sv
module jerk_limited_velocity_ramp_top_tb;

  typedef struct packed {
    logic [31:0] vel;
    logic [31:0] acc;
    logic [31:0] jrk;
  } motion_t;

  class velocity_ramp_scoreboard;
    longint unsigned accel_lim;
    longint unsigned jerk_lim;
    longint unsigned tick;
    longint vel;
    longint acc;
    motion_t expected_motion[$];
    int errors;

    function new();
      accel_lim = jlvr_pkg::MAX_ACCEL_RST;
      jerk_lim  = jlvr_pkg::MAX_JERK_RST;
      tick      = jlvr_pkg::CYCLE_TIME_RST;
      vel = 0;
      acc = 0;
      errors = 0;
    endfunction

    function longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint unsigned magnitude(longint x);
      longint unsigned m;
      m = (x < 0) ? longint'(0) - x : x;
      if (m > (64'd1 << 62)) m = 64'd1 << 62;
      return m;
    endfunction

    function longint unsigned scale_t(longint unsigned m, longint unsigned t, int s);
      longint unsigned r;
      r = (m >> 24) * t + (((m & 64'hFFFFFF) * t) >> 24);
      return r >> s;
    endfunction

    function longint sscale_t(longint x, longint unsigned t, int s);
      longint unsigned r;
      r = scale_t(magnitude(x), t, s);
      return (x < 0) ? -longint'(r) : longint'(r);
    endfunction

    function longint unsigned div_by_t(longint unsigned m, longint unsigned t);
      longint unsigned q, r;
      q = m / t;
      r = m % t;
      if (q >= (64'd1 << 37)) return 64'd1 << 62;
      return (q << 25) + ((r << 25) / t);
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void note_transfer(logic rt, logic signed [31:0] tgt,
                                logic signed [31:0] pv, logic signed [31:0] pa);
      longint tv, err, req, na, dv, da, jk, ma, v, a, diff;
      longint unsigned t, mj, dmax, tiny, m, rad, sq, sum, q;
      motion_t e;
      if (rt == jlvr_pkg::REQ_PRESET) begin
        vel = clip32(longint'(pv));
        acc = clip32(longint'(pa));
        e.vel = vel[31:0];
        e.acc = acc[31:0];
        e.jrk = '0;
        expected_motion.push_back(e);
        return;
      end
      v = vel;
      a = acc;
      tv = longint'(tgt);
      t = (tick != 0) ? tick : 1;
      mj = jerk_lim;
      ma = longint'(accel_lim);
      dmax = scale_t(mj, t, 0);
      tiny = scale_t(dmax, t, 0) / 1000;
      err = tv - v;
      if (err > longint'(tiny) || err < -longint'(tiny)) begin
        m = magnitude(err);
        sq = dmax * dmax;
        if (mj != 0 && m > 64'hFFFF_FFFF_FFFF_FFFF / (2 * mj)) begin
          rad = 64'hFFFF_FFFF_FFFF_FFFF;
        end else begin
          rad = 2 * mj * m;
          sum = rad + sq;
          rad = (sum < rad) ? 64'hFFFF_FFFF_FFFF_FFFF : sum;
        end
        m = int_sqrt(rad) - dmax;
        req = (err > 0) ? longint'(m) : -longint'(m);
      end else begin
        req = 0;
      end
      if (req > ma) req = ma;
      else if (req < -ma) req = -ma;
      if (req > a + longint'(dmax)) na = a + longint'(dmax);
      else if (req < a - longint'(dmax)) na = a - longint'(dmax);
      else na = req;
      dv = sscale_t(a + na, t, 1);
      if ((dv < 0 && tv < v && v + dv < tv) || (dv > 0 && v < tv && tv < v + dv)) begin
        diff = tv - v;
        q = div_by_t(magnitude(diff), t);
        na = ((diff < 0) ? -longint'(q) : longint'(q)) - a;
        if (na >= ma) begin
          na = ma;
          v += sscale_t(a + na, t, 1);
        end else begin
          v = tv;
        end
      end else begin
        v += dv;
      end
      da = na - a;
      if (da > (64'sd1 << 38)) da = 64'sd1 << 38;
      else if (da < -(64'sd1 << 38)) da = -(64'sd1 << 38);
      jk = (da * 16777216) / longint'(t);
      if (jk > longint'(mj)) begin
        jk = longint'(mj);
        na = a + longint'(dmax);
      end else if (jk < -longint'(mj)) begin
        jk = -longint'(mj);
        na = a - longint'(dmax);
      end
      vel = clip32(v);
      acc = clip32(na);
      e.vel = vel[31:0];
      e.acc = acc[31:0];
      e.jrk = jk[31:0];
      expected_motion.push_back(e);
    endfunction

    function void check_result(logic [31:0] v, logic [31:0] a, logic [31:0] j);
      motion_t e;
      if (expected_motion.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result v=%h a=%h j=%h", v, a, j);
        return;
      end
      e = expected_motion.pop_front();
      if (e.vel !== v || e.acc !== a || e.jrk !== j) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp v=%h a=%h j=%h got v=%h a=%h j=%h",
                   e.vel, e.acc, e.jrk, v, a, j);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [jlvr_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [jlvr_pkg::CFG_DW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic signed [jlvr_pkg::IO_W-1:0] target_velocity_i = '0;
  logic signed [jlvr_pkg::IO_W-1:0] preset_velocity_i = '0;
  logic signed [jlvr_pkg::IO_W-1:0] preset_accel_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [jlvr_pkg::IO_W-1:0] new_velocity_o;
  logic signed [jlvr_pkg::IO_W-1:0] new_accel_o;
  logic signed [jlvr_pkg::IO_W-1:0] jerk_out_o;

  velocity_ramp_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;

  jerk_limited_velocity_ramp_top DUT (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (sb != null && out_valid_o && !out_stall_i)
      sb.check_result(new_velocity_o, new_accel_o, jerk_out_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_tick(logic rt, logic [31:0] tgt, logic [31:0] pv, logic [31:0] pa);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    target_velocity_i <= tgt;
    preset_velocity_i <= pv;
    preset_accel_i <= pa;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(rt, tgt, pv, pa);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_motion.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_limit(jlvr_pkg::cfg_idx_e idx, logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      jlvr_pkg::CFG_MAX_ACCEL:  sb.accel_lim = val;
      jlvr_pkg::CFG_MAX_JERK:   sb.jerk_lim = val;
      jlvr_pkg::CFG_CYCLE_TIME: sb.tick = val[23:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_random();
    int r;
    int sh;
    longint tv;
    r = $urandom_range(99);
    sh = $urandom_range(30);
    if (r < 8) begin
      if ($urandom_range(1))
        send_tick(jlvr_pkg::REQ_PRESET, $urandom, $urandom, $urandom);
      else
        send_tick(jlvr_pkg::REQ_PRESET, $urandom, $urandom >> sh, $signed($urandom) >>> sh);
    end else if (r < 30) begin
      send_tick(jlvr_pkg::REQ_STEP, $urandom, $urandom, $urandom);
    end else begin
      tv = sb.clip32(sb.vel + longint'($signed($urandom) >>> sh));
      send_tick(jlvr_pkg::REQ_STEP, tv[31:0], $urandom, $urandom);
    end
  endtask

  initial begin
    #100_000_000;
    $display("jerk_limited_velocity_ramp_top_tb: errors");
    $finish;
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(jlvr_pkg::REQ_STEP, 32'sh0001_0000, 0, 0);
    send_tick(jlvr_pkg::REQ_STEP, 32'sh0001_0000, 0, 0);
    send_tick(jlvr_pkg::REQ_STEP, sb.vel[31:0], 0, 0);
    send_tick(jlvr_pkg::REQ_PRESET, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(jlvr_pkg::REQ_STEP, 32'h8000_0000, 0, 0);
    send_tick(jlvr_pkg::REQ_PRESET, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_tick(jlvr_pkg::REQ_STEP, 32'h7FFF_FFFF, 0, 0);
    send_tick(jlvr_pkg::REQ_PRESET, 0, 32'h0000_1000, 32'h0001_0000);
    send_tick(jlvr_pkg::REQ_STEP, 32'h0000_1001, 0, 0);
    send_tick(jlvr_pkg::REQ_PRESET, 0, 0, 0);
    send_tick(jlvr_pkg::REQ_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    write_limit(jlvr_pkg::CFG_MAX_ACCEL, 31'h7FFF_FFFF);
    write_limit(jlvr_pkg::CFG_MAX_JERK, 31'h7FFF_FFFF);
    write_limit(jlvr_pkg::CFG_CYCLE_TIME, 31'h00FF_FFFF);
    send_tick(jlvr_pkg::REQ_STEP, 32'h7FFF_FFFF, 0, 0);
    send_tick(jlvr_pkg::REQ_STEP, 32'h8000_0000, 0, 0);
    send_tick(jlvr_pkg::REQ_PRESET, 0, 32'h0000_0000, 32'h4000_0000);
    send_tick(jlvr_pkg::REQ_STEP, 32'h0000_0100, 0, 0);
    send_tick(jlvr_pkg::REQ_STEP, 32'h0000_0000, 0, 0);
    drain();
    write_limit(jlvr_pkg::CFG_MAX_ACCEL, 31'd0);
    write_limit(jlvr_pkg::CFG_MAX_JERK, 31'd0);
    write_limit(jlvr_pkg::CFG_CYCLE_TIME, 31'd0);
    send_tick(jlvr_pkg::REQ_STEP, 32'h1234_5678, 0, 0);
    send_tick(jlvr_pkg::REQ_STEP, 32'h8765_4321, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      case (ph)
        0: begin
          write_limit(jlvr_pkg::CFG_MAX_ACCEL, 31'd65536);
          write_limit(jlvr_pkg::CFG_MAX_JERK, 31'd655360);
          write_limit(jlvr_pkg::CFG_CYCLE_TIME, 31'd16777);
        end
        1: begin
          write_limit(jlvr_pkg::CFG_MAX_ACCEL, 31'h7FFF_FFFF);
          write_limit(jlvr_pkg::CFG_MAX_JERK, 31'h7FFF_FFFF);
          write_limit(jlvr_pkg::CFG_CYCLE_TIME, 31'h00FF_FFFF);
        end
        2: begin
          write_limit(jlvr_pkg::CFG_MAX_ACCEL, 31'd0);
          write_limit(jlvr_pkg::CFG_MAX_JERK, 31'($urandom));
          write_limit(jlvr_pkg::CFG_CYCLE_TIME, 31'd1);
        end
        3: begin
          write_limit(jlvr_pkg::CFG_MAX_ACCEL, 31'($urandom));
          write_limit(jlvr_pkg::CFG_MAX_JERK, 31'd0);
          write_limit(jlvr_pkg::CFG_CYCLE_TIME, 31'd0);
        end
        4: begin
          write_limit(jlvr_pkg::CFG_MAX_ACCEL, 31'($urandom_range(1 << 24)));
          write_limit(jlvr_pkg::CFG_MAX_JERK, 31'($urandom_range(1 << 26)));
          write_limit(jlvr_pkg::CFG_CYCLE_TIME, 31'($urandom_range(1 << 20, 1)));
        end
        default: begin
          write_limit(jlvr_pkg::CFG_MAX_ACCEL, 31'($urandom));
          write_limit(jlvr_pkg::CFG_MAX_JERK, 31'($urandom));
          write_limit(jlvr_pkg::CFG_CYCLE_TIME, 31'($urandom));
        end
      endcase
      for (int k = 0; k < 115; k++) begin
        if (ph == 1 && k == 50) drain();
        send_random();
      end
      drain();
    end

    repeat (500) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_motion.size() == 0) begin
      $display("jerk_limited_velocity_ramp_top_tb: clean");
    end else begin
      $display("jerk_limited_velocity_ramp_top_tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/jlvr_pkg.sv
rtl/jlvr_mul.sv
rtl/jlvr_div.sv
rtl/jlvr_sqrt.sv
rtl/jerk_limited_velocity_ramp_top.sv
dv/jerk_limited_velocity_ramp_top_tb.sv
